@@ rtl/u8d_pkg.sv @@
// shared types and constants of the utf-8 stream decoder
package u8d_pkg;

  localparam int unsigned CpW  = 21;
  localparam int unsigned CntW = 3;

  localparam logic [CpW-1:0] REPL_CP   = 21'h00FFFD;
  localparam logic [CpW-1:0] MAX_CP    = 21'h10FFFF;
  localparam logic [CpW-1:0] SURR_LO   = 21'h00D800;
  localparam logic [CpW-1:0] SURR_HI   = 21'h00DFFF;
  localparam logic [CpW-1:0] MIN_CP_2B = 21'h000080;
  localparam logic [CpW-1:0] MIN_CP_3B = 21'h000800;
  localparam logic [CpW-1:0] MIN_CP_4B = 21'h010000;

  // continuation bytes a sequence needs
  localparam logic [1:0] NEED_NONE = 2'd0;
  localparam logic [1:0] NEED_ONE  = 2'd1;
  localparam logic [1:0] NEED_TWO  = 2'd2;
  localparam logic [1:0] NEED_THREE = 2'd3;

  // decoded outcome of one byte: count words, all but the last are replacements
  typedef struct packed {
    logic [CntW-1:0] count;
    logic [CpW-1:0]  cp;
    logic            rep;
    logic            fin;
  } step_res_t;

endpackage

@@ rtl/u8d_step.sv @@
// decode state and per-byte decode logic
module u8d_step (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            byte_in,
  input  logic                  string_end,
  output u8d_pkg::step_res_t    res
);

  logic [u8d_pkg::CpW-1:0] pv_r, pv_nxt;
  logic [1:0]              need_r, need_nxt;
  logic [1:0]              taken_r, taken_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= '0;
      need_r  <= u8d_pkg::NEED_NONE;
      taken_r <= '0;
    end else if (step) begin
      pv_r    <= pv_nxt;
      need_r  <= need_nxt;
      taken_r <= taken_nxt;
    end
  end

  always_comb begin
    logic                    cont;
    logic                    sb_emit;
    logic [u8d_pkg::CpW-1:0] sb_cp;
    logic                    sb_rep;
    logic [1:0]              sb_need;
    logic [u8d_pkg::CpW-1:0] sb_pv;
    logic [u8d_pkg::CpW-1:0] pv_s;
    logic [1:0]              taken_s;
    logic                    bad;
    logic [u8d_pkg::CntW-1:0] pre;

    cont    = (byte_in[7:6] == 2'b10);
    // handling of a byte with no sequence open
    sb_emit = 1'b1;
    sb_cp   = u8d_pkg::REPL_CP;
    sb_rep  = 1'b1;
    sb_need = u8d_pkg::NEED_NONE;
    sb_pv   = '0;
    priority if (!byte_in[7]) begin
      sb_cp  = {13'd0, byte_in};
      sb_rep = 1'b0;
    end else if (byte_in[7:5] == 3'b110) begin
      sb_emit = 1'b0;
      sb_need = u8d_pkg::NEED_ONE;
      sb_pv   = {16'd0, byte_in[4:0]};
    end else if (byte_in[7:4] == 4'b1110) begin
      sb_emit = 1'b0;
      sb_need = u8d_pkg::NEED_TWO;
      sb_pv   = {17'd0, byte_in[3:0]};
    end else if (byte_in[7:3] == 5'b11110) begin
      sb_emit = 1'b0;
      sb_need = u8d_pkg::NEED_THREE;
      sb_pv   = {18'd0, byte_in[2:0]};
    end else begin
      sb_emit = 1'b1;
    end

    pv_s    = {pv_r[14:0], byte_in[5:0]};
    taken_s = taken_r + 2'd1;
    bad = ((need_r == u8d_pkg::NEED_ONE)   && (pv_s < u8d_pkg::MIN_CP_2B)) ||
          ((need_r == u8d_pkg::NEED_TWO)   && (pv_s < u8d_pkg::MIN_CP_3B)) ||
          ((need_r == u8d_pkg::NEED_THREE) && (pv_s < u8d_pkg::MIN_CP_4B)) ||
          (pv_s > u8d_pkg::MAX_CP) ||
          ((pv_s >= u8d_pkg::SURR_LO) && (pv_s <= u8d_pkg::SURR_HI));
    pre = {1'b0, taken_r} + 3'd1;

    res.count = '0;
    res.cp    = u8d_pkg::REPL_CP;
    res.rep   = 1'b1;
    res.fin   = string_end;
    pv_nxt    = '0;
    need_nxt  = u8d_pkg::NEED_NONE;
    taken_nxt = '0;

    if (need_r != u8d_pkg::NEED_NONE) begin
      if (cont) begin
        if (taken_s >= need_r) begin
          // sequence complete
          res.count = 3'd1;
          res.cp    = bad ? u8d_pkg::REPL_CP : pv_s;
          res.rep   = bad;
        end else if (string_end) begin
          res.count = {1'b0, taken_s} + 3'd1;
        end else begin
          pv_nxt    = pv_s;
          need_nxt  = need_r;
          taken_nxt = taken_s;
        end
      end else begin
        // broken sequence: flush lead and taken bytes, then restart
        if (sb_emit) begin
          res.count = pre + 3'd1;
          res.cp    = sb_cp;
          res.rep   = sb_rep;
        end else if (string_end) begin
          res.count = pre + 3'd1;
        end else begin
          res.count = pre;
          pv_nxt    = sb_pv;
          need_nxt  = sb_need;
        end
      end
    end else begin
      if (sb_emit) begin
        res.count = 3'd1;
        res.cp    = sb_cp;
        res.rep   = sb_rep;
      end else if (string_end) begin
        res.count = 3'd1;
      end else begin
        pv_nxt   = sb_pv;
        need_nxt = sb_need;
      end
    end
  end

endmodule

@@ rtl/u8d_out.sv @@
// result register that plays out the words of one decoded byte
module u8d_out (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  u8d_pkg::step_res_t   res,
  output logic                 free,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,
  output logic [1:0]           out_tuser,
  output logic                 out_tlast
);

  logic [u8d_pkg::CntW-1:0] remain_r, remain_nxt;
  logic [u8d_pkg::CpW-1:0]  cp_r;
  logic                     rep_r;
  logic                     fin_r;
  logic                     lastw;
  logic                     take;

  assign lastw = (remain_r == 3'd1);
  assign take  = out_tvalid && out_tready;
  assign free  = (remain_r == '0) || (lastw && out_tready);

  always_comb begin
    remain_nxt = remain_r;
    if (take) begin
      remain_nxt = remain_r - 3'd1;
    end
    if (load) begin
      remain_nxt = res.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r <= '0;
    end else begin
      remain_r <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r  <= res.cp;
      rep_r <= res.rep;
      fin_r <= res.fin;
    end
  end

  assign out_tvalid = (remain_r != '0);
  assign out_tdata  = {3'd0, lastw ? cp_r : u8d_pkg::REPL_CP};
  assign out_tuser  = {lastw, lastw ? rep_r : 1'b1};
  assign out_tlast  = lastw && fin_r;

endmodule

@@ rtl/utf8_stream_decoder.sv @@
// top level of the utf-8 stream decoder
// Decodes a UTF-8 byte stream, one byte per input word, into Unicode code points, one per
// output word. A byte sits in an input register while its decode runs, and the result
// register then delivers its words: ASCII and completing bytes give one word, registered in
// the input register and then in the result register, so well-formed text streams at one
// byte per clock while the receiver is ready. A byte that breaks or ends an open sequence
// can give up to four words (U+FFFD for the lead and each continuation byte taken, then the
// byte's own result); the result register delivers one word per cycle while the receiver is
// ready, and the held byte does not move on until the last of those words is being taken.
// Bytes that only open or extend a sequence give no word. The input is taken while a result
// still waits if the input register is empty or its held byte moves on.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tlast,   // string_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic [1:0]  out_tuser,  // [0] replaced, [1] run_last
  output logic        out_tlast   // final_of_string
);

  // held input word
  logic               in_valid_r, in_valid_nxt;
  logic [7:0]         byte_r;
  logic               end_r;
  logic               free;
  logic               advance;
  logic               accept;
  u8d_pkg::step_res_t res;

  // the held byte moves on once the result register can take its words
  assign advance   = in_valid_r && free;
  assign in_tready = !in_valid_r || free;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (advance) begin
      in_valid_nxt = 1'b0;
    end
    if (accept) begin
      in_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_tdata;
      end_r  <= in_tlast;
    end
  end

  // decode state and combinational decode of the held byte
  u8d_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .byte_in    (byte_r),
    .string_end (end_r),
    .res        (res)
  );

  // result register; bytes that give no word leave it untouched
  u8d_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && (res.count != '0)),
    .res        (res),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
